FILE: rtl/srsc_pkg.sv
package srsc_pkg;

    localparam int SYM_W   = 8;
    localparam int DIGIT_W = 4;
    localparam int RADIX_W = 5;
    localparam int ALPHA_W = 64;
    localparam int NUM_SYM = 16;
    localparam int IDX_W   = 2;

    localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;

    localparam logic [RADIX_W-1:0] RADIX_RESET   = 5'd10;
    localparam logic [ALPHA_W-1:0] SYM_LOW_RESET = 64'h3736353433323130;
    localparam logic [ALPHA_W-1:0] SYM_HIGH_RESET = 64'h4645444342413938;

    localparam logic [IDX_W-1:0] REG_RADIX    = 2'd0;
    localparam logic [IDX_W-1:0] REG_SYM_LOW  = 2'd1;
    localparam logic [IDX_W-1:0] REG_SYM_HIGH = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_STORE,
        ST_SIGN,
        ST_SIGN_EMIT,
        ST_READ,
        ST_LOAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic init;
        logic div_step;
        logic store;
        logic load_sign;
        logic load_digit;
        logic dec;
    } cmd_t;

    typedef struct packed {
        logic alpha_ok;
        logic neg;
        logic bit_last;
        logic quot_zero;
        logic cnt_one;
    } sts_t;

endpackage

FILE: rtl/srsc_ram.sv
module srsc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/srsc_ctrl.sv
module srsc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  srsc_pkg::sts_t sts,
    output srsc_pkg::cmd_t cmd
);

    srsc_pkg::state_t state_reg;
    srsc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srsc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srsc_pkg::ST_IDLE: begin
                if (s_valid) state_next = srsc_pkg::ST_CHECK;
            end
            srsc_pkg::ST_CHECK: begin
                state_next = sts.alpha_ok ? srsc_pkg::ST_DIV : srsc_pkg::ST_IDLE;
            end
            srsc_pkg::ST_DIV: begin
                if (sts.bit_last) state_next = srsc_pkg::ST_STORE;
            end
            srsc_pkg::ST_STORE: begin
                if (!sts.quot_zero) begin
                    state_next = srsc_pkg::ST_DIV;
                end else if (sts.neg) begin
                    state_next = srsc_pkg::ST_SIGN;
                end else begin
                    state_next = srsc_pkg::ST_READ;
                end
            end
            srsc_pkg::ST_SIGN:      state_next = srsc_pkg::ST_SIGN_EMIT;
            srsc_pkg::ST_SIGN_EMIT: begin
                if (m_ready) state_next = srsc_pkg::ST_READ;
            end
            srsc_pkg::ST_READ:      state_next = srsc_pkg::ST_LOAD;
            srsc_pkg::ST_LOAD:      state_next = srsc_pkg::ST_EMIT;
            srsc_pkg::ST_EMIT: begin
                if (m_ready) begin
                    state_next = sts.cnt_one ? srsc_pkg::ST_IDLE : srsc_pkg::ST_READ;
                end
            end
            default:                state_next = srsc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            srsc_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            srsc_pkg::ST_CHECK:     cmd.init       = 1'b1;
            srsc_pkg::ST_DIV:       cmd.div_step   = 1'b1;
            srsc_pkg::ST_STORE:     cmd.store      = 1'b1;
            srsc_pkg::ST_SIGN:      cmd.load_sign  = 1'b1;
            srsc_pkg::ST_SIGN_EMIT: m_valid        = 1'b1;
            srsc_pkg::ST_READ:      cmd            = '0;
            srsc_pkg::ST_LOAD:      cmd.load_digit = 1'b1;
            srsc_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                cmd.dec = m_ready;
            end
            default:                cmd            = '0;
        endcase
    end

endmodule

FILE: rtl/srsc_datapath.sv
module srsc_datapath #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [srsc_pkg::IDX_W-1:0]        cfg_index,
    input  logic [srsc_pkg::ALPHA_W-1:0]      cfg_data,
    input  logic signed [VALUE_BITS-1:0]      s_value,
    input  srsc_pkg::cmd_t                    cmd,
    output srsc_pkg::sts_t                    sts,
    output logic [srsc_pkg::SYM_W-1:0]        m_symbol,
    output logic                              m_last
);

    localparam int AW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int BW = $clog2(VALUE_BITS);

    logic [srsc_pkg::RADIX_W-1:0] radix_reg;
    logic [srsc_pkg::ALPHA_W-1:0] sym_low_reg;
    logic [srsc_pkg::ALPHA_W-1:0] sym_high_reg;
    logic                         ok_reg;
    logic                         ok_next;

    logic [VALUE_BITS-1:0]        mag_reg;
    logic                         neg_reg;
    logic [srsc_pkg::DIGIT_W-1:0] rem_reg;
    logic [srsc_pkg::DIGIT_W-1:0] rem_next;
    logic [BW-1:0]                bit_reg;
    logic [CW-1:0]                cnt_reg;
    logic [srsc_pkg::SYM_W-1:0]   sym_reg;
    logic                         last_reg;

    logic [srsc_pkg::SYM_W-1:0]   sym_tab [srsc_pkg::NUM_SYM];
    logic [srsc_pkg::RADIX_W-1:0] trial;
    logic                         fits;
    logic [srsc_pkg::DIGIT_W-1:0] rd_digit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg    <= srsc_pkg::RADIX_RESET;
            sym_low_reg  <= srsc_pkg::SYM_LOW_RESET;
            sym_high_reg <= srsc_pkg::SYM_HIGH_RESET;
            ok_reg       <= 1'b1;
        end else begin
            ok_reg <= ok_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    srsc_pkg::REG_RADIX:    radix_reg    <= cfg_data[srsc_pkg::RADIX_W-1:0];
                    srsc_pkg::REG_SYM_LOW:  sym_low_reg  <= cfg_data;
                    srsc_pkg::REG_SYM_HIGH: sym_high_reg <= cfg_data;
                    default:                radix_reg    <= radix_reg;
                endcase
            end
        end
    end

    always_comb begin
        for (int i = 0; i < srsc_pkg::NUM_SYM / 2; i++) begin
            sym_tab[i]                          = sym_low_reg[8*i +: 8];
            sym_tab[i + srsc_pkg::NUM_SYM / 2]  = sym_high_reg[8*i +: 8];
        end
    end

    always_comb begin
        ok_next = (radix_reg >= srsc_pkg::RADIX_W'(2))
               && (radix_reg <= srsc_pkg::RADIX_W'(MAX_RADIX));
        for (int i = 0; i < srsc_pkg::NUM_SYM; i++) begin
            if (srsc_pkg::RADIX_W'(i) < radix_reg) begin
                if (sym_tab[i] == '0 || sym_tab[i] == srsc_pkg::SIGN_PLUS
                        || sym_tab[i] == srsc_pkg::SIGN_MINUS) begin
                    ok_next = 1'b0;
                end
                for (int j = i + 1; j < srsc_pkg::NUM_SYM; j++) begin
                    if (srsc_pkg::RADIX_W'(j) < radix_reg && sym_tab[i] == sym_tab[j]) begin
                        ok_next = 1'b0;
                    end
                end
            end
        end
    end

    assign trial    = {rem_reg, mag_reg[VALUE_BITS-1]};
    assign fits     = trial >= radix_reg;
    assign rem_next = fits ? srsc_pkg::DIGIT_W'(trial - radix_reg)
                           : trial[srsc_pkg::DIGIT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg <= '0;
            neg_reg <= 1'b0;
            rem_reg <= '0;
            bit_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cmd.capture) begin
                neg_reg <= s_value[VALUE_BITS-1];
                mag_reg <= s_value[VALUE_BITS-1] ? VALUE_BITS'(~s_value + 1'b1)
                                                 : VALUE_BITS'(s_value);
            end
            if (cmd.init) begin
                rem_reg <= '0;
                bit_reg <= '0;
                cnt_reg <= '0;
            end
            if (cmd.div_step) begin
                rem_reg <= rem_next;
                mag_reg <= {mag_reg[VALUE_BITS-2:0], fits};
                bit_reg <= bit_reg + 1'b1;
            end
            if (cmd.store) begin
                rem_reg <= '0;
                bit_reg <= '0;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.dec) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    srsc_ram #(
        .WIDTH (srsc_pkg::DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .aclk    (aclk),
        .wr_en   (cmd.store),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (rem_reg),
        .rd_addr (AW'(cnt_reg - 1'b1)),
        .rd_data (rd_digit)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_sign) begin
            sym_reg  <= srsc_pkg::SIGN_MINUS;
            last_reg <= 1'b0;
        end
        if (cmd.load_digit) begin
            sym_reg  <= sym_tab[rd_digit];
            last_reg <= (cnt_reg == CW'(1));
        end
    end

    assign sts.alpha_ok  = ok_reg;
    assign sts.neg       = neg_reg;
    assign sts.bit_last  = (bit_reg == BW'(VALUE_BITS - 1));
    assign sts.quot_zero = (mag_reg == '0);
    assign sts.cnt_one   = (cnt_reg == CW'(1));

    assign m_symbol = sym_reg;
    assign m_last   = last_reg;

endmodule

FILE: rtl/signed_radix_to_symbol_converter_top.sv
// Channel   Handshake          Payload
// input     s_valid/s_ready    s_value  (VALUE_BITS, signed)
// result    m_valid/m_ready    m_symbol (8), m_last (1)
// config    cfg_wr_en          cfg_index (2), cfg_data (64)
//
// One number at a time; s_ready is high only while idle.
// Each digit comes from the one-bit-per-cycle restoring divider; a minus sign
// goes first, then digits are read back from the digit RAM, top digit first.
// An invalid radix or alphabet drops the number in the check state, with no result.
// Result stalls hold the controller in its sign or digit emit state.
// aresetn is synchronous; config registers return to radix 10, alphabet "0..9A..F".
module signed_radix_to_symbol_converter_top #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [srsc_pkg::SYM_W-1:0]   m_symbol,
    output logic                         m_last,
    input  logic                         cfg_wr_en,
    input  logic [srsc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [srsc_pkg::ALPHA_W-1:0] cfg_data
);

    srsc_pkg::cmd_t cmd;
    srsc_pkg::sts_t sts;

    srsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    srsc_datapath #(
        .MAX_RADIX  (MAX_RADIX),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_value   (s_value),
        .cmd       (cmd),
        .sts       (sts),
        .m_symbol  (m_symbol),
        .m_last    (m_last)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid)
        else $error("input transfer while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second input taken before the first finished");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> s_ready && !m_valid)
        else $error("block not idle after final symbol transfer");

    a_div_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !m_valid && !s_ready)
        else $error("handshake active during division");

endmodule
